/* design/sfd_pkg.sv */
package sfd_pkg;

    // Payload length field width after masking (8..16)
    localparam int LENGTH_WIDTH = 16;

    localparam int BYTE_WIDTH      = 8;
    localparam int KIND_WIDTH      = 2;
    localparam int FRAME_LEN_WIDTH = 16;
    localparam int PHASE_WIDTH     = 3;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;

    // Phase codes
    localparam logic [PHASE_WIDTH-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_LEN_LO  = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_CHECK   = 3'd4;

    // Result kinds
    localparam logic [KIND_WIDTH-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_GOOD     = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_BAD_SUM  = 2'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_TOO_LONG = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_PAYLOAD  = 1'd1;

    // Register reset values
    localparam logic [BYTE_WIDTH-1:0]      START_MARKER_RESET = 8'h33;
    localparam logic [FRAME_LEN_WIDTH-1:0] MAX_PAYLOAD_RESET  = 16'd296;

endpackage

/* design/serial_frame_deframer.sv */
// An accepted byte goes to the input register, its result word then to the result register.
// Throughput: one byte per cycle unless a held result word waits for out_ready; one short logic pass.
// Bytes that cause no result (hunt, length, ...) still take one slot in the input register.
// Reset (rst_n low, async): hunting for the start byte, XOR/length/count cleared,
// both pipeline registers empty, start_marker = 0x33, max_payload = 296.
module serial_frame_deframer
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // received byte stream
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [sfd_pkg::BYTE_WIDTH-1:0]         rx_byte,

    // result words
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sfd_pkg::KIND_WIDTH-1:0]         out_kind,
    output logic [sfd_pkg::BYTE_WIDTH-1:0]         out_byte,
    output logic [sfd_pkg::FRAME_LEN_WIDTH-1:0]    frame_length,

    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [sfd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int LW = sfd_pkg::LENGTH_WIDTH;
    localparam int BW = sfd_pkg::BYTE_WIDTH;
    localparam int FW = sfd_pkg::FRAME_LEN_WIDTH;

    // configuration registers
    logic [BW-1:0] start_marker_reg;
    logic [FW-1:0] max_payload_reg;

    // input register
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;

    // frame state
    logic [sfd_pkg::PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [BW-1:0]                   xor_reg, xor_next;
    logic [BW-1:0]                   len_lo_reg, len_lo_next;
    logic [LW-1:0]                   payload_len_reg, payload_len_next;
    logic [LW-1:0]                   bytes_seen_reg, bytes_seen_next;

    // result register
    logic                             out_valid_reg;
    logic [sfd_pkg::KIND_WIDTH-1:0]   out_kind_reg, out_kind_next;
    logic [BW-1:0]                    out_byte_reg, out_byte_next;
    logic [FW-1:0]                    frame_len_reg, frame_len_next;
    logic                             emit_next;

    logic          out_free;   // result register can take a new word this cycle
    logic          step;       // byte in the input register is processed this cycle
    logic [2*BW-1:0] len_raw;
    logic [LW-1:0]   len_masked;
    logic [LW-1:0]   seen_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_byte     = out_byte_reg;
    assign frame_length = frame_len_reg;

    // length high byte arrives in in_byte_reg; low byte was held
    assign len_raw    = {in_byte_reg, len_lo_reg};
    assign len_masked = len_raw[LW-1:0];
    assign seen_inc   = bytes_seen_reg + LW'(1);

    // ------------------------------------------------------------------
    // Per-byte state update and result selection
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        len_lo_next      = len_lo_reg;
        payload_len_next = payload_len_reg;
        bytes_seen_next  = bytes_seen_reg;
        emit_next        = 1'b0;
        out_kind_next    = sfd_pkg::KIND_DATA;
        out_byte_next    = '0;
        frame_len_next   = '0;

        case (phase_reg)
            sfd_pkg::PH_LEN_LO:
            begin
                xor_next    = xor_reg ^ in_byte_reg;
                len_lo_next = in_byte_reg;
                phase_next  = sfd_pkg::PH_LEN_HI;
            end
            sfd_pkg::PH_LEN_HI:
            begin
                xor_next         = xor_reg ^ in_byte_reg;
                payload_len_next = len_masked;
                bytes_seen_next  = '0;
                if (FW'(len_masked) > max_payload_reg)
                begin
                    // header claims more than allowed: abort, hunt again
                    phase_next     = sfd_pkg::PH_HUNT;
                    emit_next      = 1'b1;
                    out_kind_next  = sfd_pkg::KIND_TOO_LONG;
                    frame_len_next = FW'(len_masked);
                end
                else if (len_masked == '0)
                begin
                    phase_next = sfd_pkg::PH_CHECK;
                end
                else
                begin
                    phase_next = sfd_pkg::PH_PAYLOAD;
                end
            end
            sfd_pkg::PH_PAYLOAD:
            begin
                xor_next        = xor_reg ^ in_byte_reg;
                bytes_seen_next = seen_inc;
                if (seen_inc >= payload_len_reg)
                begin
                    phase_next = sfd_pkg::PH_CHECK;
                end
                emit_next     = 1'b1;
                out_kind_next = sfd_pkg::KIND_DATA;
                out_byte_next = in_byte_reg;
            end
            sfd_pkg::PH_CHECK:
            begin
                phase_next     = sfd_pkg::PH_HUNT;
                emit_next      = 1'b1;
                out_kind_next  = (in_byte_reg == xor_reg) ? sfd_pkg::KIND_GOOD
                                                          : sfd_pkg::KIND_BAD_SUM;
                frame_len_next = FW'(payload_len_reg);
            end
            default:
            begin
                // hunting; unused codes fall in here too
                phase_next = sfd_pkg::PH_HUNT;
                if (in_byte_reg == start_marker_reg)
                begin
                    xor_next         = in_byte_reg;
                    payload_len_next = '0;
                    bytes_seen_next  = '0;
                    phase_next       = sfd_pkg::PH_LEN_LO;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= sfd_pkg::START_MARKER_RESET;
            max_payload_reg  <= sfd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfd_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data[BW-1:0];
                sfd_pkg::CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= sfd_pkg::PH_HUNT;
            xor_reg         <= '0;
            len_lo_reg      <= '0;
            payload_len_reg <= '0;
            bytes_seen_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                phase_reg       <= phase_next;
                xor_reg         <= xor_next;
                len_lo_reg      <= len_lo_next;
                payload_len_reg <= payload_len_next;
                bytes_seen_reg  <= bytes_seen_next;
            end
            if (out_free)
            begin
                out_valid_reg <= step && emit_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && emit_next)
        begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            frame_len_reg <= frame_len_next;
        end
    end

endmodule

/* test/serial_frame_deframer_tb.sv */
module serial_frame_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Two pipeline registers inside the block; PIPE_DRAIN gives a byte that produced
    // no word the time it needs to be fully absorbed.
    localparam int PIPE_DRAIN  = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 100;
    localparam int DIR_ROWS    = 23;

    // One result word as the block presents it.
    typedef struct packed {
        logic [sfd_pkg::KIND_WIDTH-1:0]      kind;
        logic [sfd_pkg::BYTE_WIDTH-1:0]      data;
        logic [sfd_pkg::FRAME_LEN_WIDTH-1:0] len;
    } word_t;

    // Directed row: one link byte, plus the word it must produce when that is
    // obvious by inspection. Rows without a hand-written word go to the predictor.
    typedef struct {
        logic [sfd_pkg::BYTE_WIDTH-1:0] rx;
        bit                             typed;
        word_t                          word;
    } row_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic [sfd_pkg::BYTE_WIDTH-1:0]      rx_byte      = '0;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic [sfd_pkg::KIND_WIDTH-1:0]      out_kind;
    logic [sfd_pkg::BYTE_WIDTH-1:0]      out_byte;
    logic [sfd_pkg::FRAME_LEN_WIDTH-1:0] frame_length;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [sfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index    = sfd_pkg::CFG_START_MARKER;
    logic [sfd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data     = '0;

    // Deframer shadow state, advanced once per accepted link byte.
    logic [sfd_pkg::PHASE_WIDTH-1:0]     rx_phase   = sfd_pkg::PH_HUNT;
    logic [sfd_pkg::BYTE_WIDTH-1:0]      rx_xor     = '0;
    logic [15:0]                         rx_len     = '0;
    logic [15:0]                         rx_count   = '0;
    logic [sfd_pkg::BYTE_WIDTH-1:0]      cur_marker = sfd_pkg::START_MARKER_RESET;
    logic [15:0]                         cur_max    = sfd_pkg::MAX_PAYLOAD_RESET;

    word_t pending_words[$];
    int    fail_count  = 0;
    int    sent_bytes  = 0;
    int    cycle_count = 0;
    int    stall_left  = 0;
    bit    steady      = 1'b0;   // when set, neither side inserts bubbles

    // Directed frames, all under the reset configuration (marker 0x33, max 296):
    // junk while hunting, a good two-byte frame, an empty frame, a frame with a
    // start byte as payload and a wrong checksum, a length one over the maximum,
    // and the largest possible length.
    row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'hFF, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h33, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h02, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h00, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'hFF, 1'b1, '{sfd_pkg::KIND_DATA,     8'hFF, 16'd0}},
        '{8'h00, 1'b1, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'hCE, 1'b1, '{sfd_pkg::KIND_GOOD,     8'h00, 16'd2}},
        '{8'h33, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h00, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h00, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h33, 1'b1, '{sfd_pkg::KIND_GOOD,     8'h00, 16'd0}},
        '{8'h33, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h01, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h00, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h33, 1'b1, '{sfd_pkg::KIND_DATA,     8'h33, 16'd0}},
        '{8'h00, 1'b1, '{sfd_pkg::KIND_BAD_SUM,  8'h00, 16'd1}},
        '{8'h33, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h29, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'h01, 1'b1, '{sfd_pkg::KIND_TOO_LONG, 8'h00, 16'd297}},
        '{8'h33, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'hFF, 1'b0, '{sfd_pkg::KIND_DATA,     8'h00, 16'd0}},
        '{8'hFF, 1'b1, '{sfd_pkg::KIND_TOO_LONG, 8'h00, 16'd65535}}
    };

    serial_frame_deframer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .frame_length (frame_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bubble length: none while steady is set; otherwise mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance the shadow deframer by one link byte; returns 1 with the word
    // the block must emit for it, or 0 when the byte produces nothing.
    function automatic bit deframe_step(input logic [sfd_pkg::BYTE_WIDTH-1:0] b,
                                        output word_t w);
        logic [16:0] lmask;
        logic [15:0] len;
        lmask = (17'd1 << sfd_pkg::LENGTH_WIDTH) - 17'd1;
        w = '0;
        deframe_step = 1'b0;
        case (rx_phase)
            sfd_pkg::PH_LEN_LO:
            begin
                rx_xor   = rx_xor ^ b;
                rx_len   = {8'h00, b};
                rx_phase = sfd_pkg::PH_LEN_HI;
            end
            sfd_pkg::PH_LEN_HI:
            begin
                rx_xor   = rx_xor ^ b;
                // masked length; checksum already took both raw bytes
                len      = {b, rx_len[7:0]} & lmask[15:0];
                rx_len   = len;
                rx_count = '0;
                if (len > cur_max)
                begin
                    rx_phase     = sfd_pkg::PH_HUNT;
                    w            = '{sfd_pkg::KIND_TOO_LONG, 8'h00, len};
                    deframe_step = 1'b1;
                end
                else
                begin
                    rx_phase = (len == 16'd0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
                end
            end
            sfd_pkg::PH_PAYLOAD:
            begin
                rx_xor   = rx_xor ^ b;
                rx_count = rx_count + 16'd1;
                if (rx_count >= rx_len)
                    rx_phase = sfd_pkg::PH_CHECK;
                w            = '{sfd_pkg::KIND_DATA, b, 16'd0};
                deframe_step = 1'b1;
            end
            sfd_pkg::PH_CHECK:
            begin
                rx_phase     = sfd_pkg::PH_HUNT;
                w            = '{(b == rx_xor) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD_SUM,
                                 8'h00, rx_len};
                deframe_step = 1'b1;
            end
            default:
            begin
                rx_phase = sfd_pkg::PH_HUNT;
                if (b == cur_marker)
                begin
                    rx_xor   = b;
                    rx_len   = '0;
                    rx_count = '0;
                    rx_phase = sfd_pkg::PH_LEN_LO;
                end
            end
        endcase
    endfunction

    // Offer one link byte, hold it until taken, then queue what it produces.
    // A hand-written word, when given, stands in for the predicted one.
    task automatic push_byte(input logic [sfd_pkg::BYTE_WIDTH-1:0] b, input bit typed,
                             input word_t tw);
        int    gap;
        word_t w;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        sent_bytes++;
        if (deframe_step(b, w))
            pending_words.push_back(typed ? tw : w);
        else if (typed)
            pending_words.push_back(tw);
    endtask

    // Sender quiet, every word back, then time for any silent byte to clear.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Both registers back to back; valid stays up between the two writes.
    task automatic write_regs(input logic [sfd_pkg::BYTE_WIDTH-1:0] marker,
                              input logic [15:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= sfd_pkg::CFG_START_MARKER;
        cfg_data  <= {8'h00, marker};
        do @(posedge clk); while (!cfg_ready);
        cur_marker = marker;
        cfg_index <= sfd_pkg::CFG_MAX_PAYLOAD;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        cur_max = limit;
        cfg_valid <= 1'b0;
    endtask

    // One random chunk of link traffic: mostly whole frames with random
    // payload, sometimes over-long headers, bad checksums or plain noise.
    task automatic send_frame();
        int                             pick;
        int                             n;
        int                             lim;
        bit                             too_long;
        logic [15:0]                    flen;
        logic [sfd_pkg::BYTE_WIDTH-1:0] b;
        logic [sfd_pkg::BYTE_WIDTH-1:0] sum;
        pick = $urandom_range(0, 99);
        // junk ahead of the frame never matches the marker, so frames stay aligned
        n = (pick < 10) ? $urandom_range(1, 4) :
            (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == cur_marker)
                b = ~b;
            push_byte(b, 1'b0, '0);
        end
        if (pick < 10)
            return;

        too_long = (pick < 22) && (cur_max != 16'hFFFF);
        if (too_long)
        begin
            flen = 16'(int'(cur_max) + 1 + $urandom_range(0, 65534 - int'(cur_max)));
        end
        else if (cur_max <= 16'd48 && $urandom_range(0, 7) == 0)
        begin
            flen = cur_max;   // exactly at the limit
        end
        else
        begin
            lim = (cur_max > 16'd12) ? 12 : int'(cur_max);
            if (cur_max > 16'd12 && $urandom_range(0, 9) == 0)
                lim = (cur_max > 16'd48) ? 48 : int'(cur_max);
            flen = 16'($urandom_range(0, lim));
        end

        sum = cur_marker ^ flen[7:0] ^ flen[15:8];
        push_byte(cur_marker, 1'b0, '0);
        push_byte(flen[7:0], 1'b0, '0);
        push_byte(flen[15:8], 1'b0, '0);
        if (too_long)
            return;
        repeat (int'(flen))
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            push_byte(b, 1'b0, '0);
        end
        b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : sum;
        push_byte(b, 1'b0, '0);
    endtask

    // Result side: compare each taken word against the oldest prediction,
    // then decide whether to start a stall.
    always @(posedge clk)
    begin : result_sink
        word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: out_kind %0d out_byte %02h frame_length %0d",
                       out_kind, out_byte, frame_length);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                    fail_count++;
                end
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                    fail_count++;
                end
                if (frame_length !== want.len)
                begin
                    $error("frame_length: expected %0d, actual %0d", want.len, frame_length);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("serial_frame_deframer verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [sfd_pkg::BYTE_WIDTH-1:0] marker_set [PHASES];
        logic [15:0]                    limit_set  [PHASES];
        int                             target;

        // reset value, both extremes, a tight limit, and two random settings;
        // phase 4 runs with no bubbles on either side
        marker_set[0] = sfd_pkg::START_MARKER_RESET;
        limit_set[0]  = sfd_pkg::MAX_PAYLOAD_RESET;
        marker_set[1] = 8'h00;        limit_set[1] = 16'd0;
        marker_set[2] = 8'hFF;        limit_set[2] = 16'hFFFF;
        marker_set[3] = 8'($urandom); limit_set[3] = 16'($urandom_range(1, 20));
        marker_set[4] = 8'($urandom); limit_set[4] = 16'($urandom_range(3, 40));
        marker_set[5] = 8'($urandom); limit_set[5] = 16'($urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows under reset configuration
        foreach (dir_rows[i])
            push_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].word);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_regs(marker_set[p], limit_set[p]);
            steady = (p == 4);
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target)
                send_frame();
            steady = 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("serial_frame_deframer verification clean");
        else
            $display("serial_frame_deframer verification failed");
        $finish;
    end

endmodule
